### sv/bphp_pkg.sv
// ----------------------------------------------------------------------------
// bphp_pkg
// Shared types and constants of the binary pixmap header parser: transaction
// payloads, configuration set, result codes and sizing.
// ----------------------------------------------------------------------------
package bphp_pkg;

  localparam int unsigned CHANNELS     = 3;
  localparam int unsigned DIM_BITS     = 14;
  localparam int unsigned PAYLOAD_BITS = 2 * DIM_BITS + 2;
  localparam int unsigned CFG_BITS     = 32;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_BITS    = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS    = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_DIM   = 2'd0;
  localparam logic [1:0] CFG_MAX_CHAN  = 2'd1;
  localparam logic [1:0] CFG_MAX_BYTES = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Final status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_TRUNC  = 3'd1;
  localparam logic [2:0] ST_MAGIC  = 3'd2;
  localparam logic [2:0] ST_HEADER = 3'd3;
  localparam logic [2:0] ST_LARGE  = 3'd4;
  localparam logic [2:0] ST_DEPTH  = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          pixel_byte;
    logic [DIM_BITS-1:0] image_width;
    logic [DIM_BITS-1:0] image_height;
    logic [2:0]          status;
    logic                end_of_run;
  } out_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] max_dimension;
    logic [7:0]          max_channel_value;
    logic [31:0]         max_encoded_bytes;
  } cfg_t;

  // Up to two results caused by one input byte, pushed in order r0, r1
  typedef struct packed {
    logic [1:0] num;
    out_item_t  r0;
    out_item_t  r1;
  } res_pair_t;

endpackage

### sv/bphp_parse.sv
// ----------------------------------------------------------------------------
// bphp_parse
// Per-byte stream state update: magic check, field parsing, payload pass
// through and final status. Produces up to two results per byte.
// ----------------------------------------------------------------------------
module bphp_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bphp_pkg::cfg_t       cfg_i,
  input  logic                 item_vld_i,
  input  bphp_pkg::in_item_t   item_i,
  output bphp_pkg::res_pair_t  res_o
);

  localparam int unsigned DW  = bphp_pkg::DIM_BITS;
  localparam int unsigned PW  = bphp_pkg::PAYLOAD_BITS;
  localparam int unsigned AW  = DW + 4;
  localparam int unsigned CW  = 33;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [3:0] MAX_DIGITS = 4'd10;

  typedef enum logic [2:0] {
    PH_MAGIC0, PH_MAGIC1, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PAYLOAD, PH_DONE, PH_ERROR
  } phase_e;

  phase_e          ph_q, ph_d;
  logic            cm_q, cm_d;
  logic [DW-1:0]   fv_q, fv_d;
  logic [3:0]      dc_q, dc_d;
  logic [DW-1:0]   ws_q, ws_d;
  logic [DW-1:0]   hs_q, hs_d;
  logic [PW-1:0]   pl_q, pl_d;
  logic [CW-1:0]   bc_q, bc_d;
  logic [2:0]      fe_q, fe_d;
  logic [2*DW-1:0] prod_q;

  logic [7:0]      b;
  logic            is_sp, is_dg;
  logic [AW-1:0]   acc;
  logic [DW-1:0]   ceil;
  logic            emit_hdr, emit_pix, fin;
  logic [2:0]      st;
  bphp_pkg::out_item_t first_r, stat_r;

  assign b     = item_i.data_byte;
  assign fin   = item_vld_i && item_i.final_byte;
  assign is_sp = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  assign is_dg = (b >= CH_ZERO) && (b <= CH_NINE);
  assign ceil  = (ph_q == PH_MAXVAL) ? DW'(cfg_i.max_channel_value) : cfg_i.max_dimension;
  assign acc   = (AW'(fv_q) << 3) + (AW'(fv_q) << 1) + AW'(b - CH_ZERO);

  always_comb begin
    ph_d = ph_q;
    cm_d = cm_q;
    fv_d = fv_q;
    dc_d = dc_q;
    ws_d = ws_q;
    hs_d = hs_q;
    pl_d = pl_q;
    bc_d = bc_q;
    fe_d = fe_q;
    emit_hdr = 1'b0;
    emit_pix = 1'b0;
    st = bphp_pkg::ST_OK;

    if (item_vld_i) begin
      // Saturate once the count is past any 32-bit limit
      bc_d = bc_q[CW-1] ? bc_q : bc_q + CW'(1);
      case (ph_q)
        PH_MAGIC0: begin
          if (b == CH_P) begin
            ph_d = PH_MAGIC1;
          end else begin
            fe_d = bphp_pkg::ST_MAGIC;
            ph_d = PH_ERROR;
          end
        end
        PH_MAGIC1: begin
          if (b == CH_SIX) begin
            ph_d = PH_WIDTH;
          end else begin
            fe_d = bphp_pkg::ST_MAGIC;
            ph_d = PH_ERROR;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (dc_q == '0 && cm_q) begin
            if (b == CH_LF) cm_d = 1'b0;
          end else if (dc_q == '0 && is_sp) begin
            cm_d = cm_q;
          end else if (dc_q == '0 && b == CH_HASH) begin
            cm_d = 1'b1;
          end else if (is_dg) begin
            if (acc > AW'(ceil)) begin
              fe_d = bphp_pkg::ST_LARGE;
              ph_d = PH_ERROR;
            end else begin
              fv_d = acc[DW-1:0];
              dc_d = dc_q + 4'd1;
              if (dc_q >= MAX_DIGITS) begin
                fe_d = bphp_pkg::ST_HEADER;
                ph_d = PH_ERROR;
              end
            end
          end else if (dc_q == '0) begin
            fe_d = bphp_pkg::ST_HEADER;
            ph_d = PH_ERROR;
          end else if (ph_q != PH_MAXVAL) begin
            // Close width or height, then treat the byte as leading filler
            if (ph_q == PH_WIDTH) begin
              ws_d = fv_q;
              ph_d = PH_HEIGHT;
            end else begin
              hs_d = fv_q;
              ph_d = PH_MAXVAL;
            end
            fv_d = '0;
            dc_d = '0;
            if (b == CH_HASH) begin
              cm_d = 1'b1;
            end else if (!is_sp) begin
              fe_d = bphp_pkg::ST_HEADER;
              ph_d = PH_ERROR;
            end
          end else if (fv_q != DW'(cfg_i.max_channel_value)) begin
            fe_d = bphp_pkg::ST_DEPTH;
            ph_d = PH_ERROR;
          end else if (!is_sp) begin
            fe_d = bphp_pkg::ST_HEADER;
            ph_d = PH_ERROR;
          end else if (ws_q == '0 || hs_q == '0 || ws_q > cfg_i.max_dimension ||
                       hs_q > cfg_i.max_dimension) begin
            fe_d = bphp_pkg::ST_LARGE;
            ph_d = PH_ERROR;
          end else begin
            // prod_q settled: height closed at least two bytes earlier
            pl_d     = PW'(prod_q) * PW'(bphp_pkg::CHANNELS);
            ph_d     = PH_PAYLOAD;
            emit_hdr = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          emit_pix = 1'b1;
          pl_d     = pl_q - PW'(1);
          if (pl_q == PW'(1)) ph_d = PH_DONE;
        end
        default: begin
          ph_d = ph_q;
        end
      endcase

      // Final status from the post-byte state
      if (bc_d[CW-1] || bc_d[31:0] > cfg_i.max_encoded_bytes) begin
        st = bphp_pkg::ST_LARGE;
      end else if (bc_d < CW'(2)) begin
        st = bphp_pkg::ST_TRUNC;
      end else if (fe_d != bphp_pkg::ST_OK) begin
        st = fe_d;
      end else if (ph_d == PH_WIDTH || ph_d == PH_HEIGHT) begin
        st = bphp_pkg::ST_HEADER;
      end else if (ph_d == PH_MAXVAL) begin
        st = (dc_d != '0 && fv_d != DW'(cfg_i.max_channel_value)) ?
             bphp_pkg::ST_DEPTH : bphp_pkg::ST_HEADER;
      end else if (ph_d == PH_PAYLOAD && pl_d != '0) begin
        st = bphp_pkg::ST_TRUNC;
      end else if (ph_d == PH_MAGIC0 || ph_d == PH_MAGIC1) begin
        st = bphp_pkg::ST_TRUNC;
      end

      if (fin) begin
        ph_d = PH_MAGIC0;
        cm_d = 1'b0;
        fv_d = '0;
        dc_d = '0;
        ws_d = '0;
        hs_d = '0;
        pl_d = '0;
        bc_d = '0;
        fe_d = bphp_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    first_r              = '0;
    first_r.kind         = emit_hdr ? bphp_pkg::KIND_HEADER : bphp_pkg::KIND_PIXEL;
    first_r.pixel_byte   = emit_pix ? b : 8'd0;
    first_r.image_width  = emit_hdr ? ws_q : '0;
    first_r.image_height = emit_hdr ? hs_q : '0;
    first_r.end_of_run   = !fin;

    stat_r            = '0;
    stat_r.kind       = bphp_pkg::KIND_STATUS;
    stat_r.status     = st;
    stat_r.end_of_run = 1'b1;

    res_o.num = 2'(emit_hdr | emit_pix) + 2'(fin);
    res_o.r0  = (emit_hdr | emit_pix) ? first_r : stat_r;
    res_o.r1  = stat_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_MAGIC0;
      cm_q   <= 1'b0;
      fv_q   <= '0;
      dc_q   <= '0;
      ws_q   <= '0;
      hs_q   <= '0;
      pl_q   <= '0;
      bc_q   <= '0;
      fe_q   <= bphp_pkg::ST_OK;
      prod_q <= '0;
    end else begin
      ph_q   <= ph_d;
      cm_q   <= cm_d;
      fv_q   <= fv_d;
      dc_q   <= dc_d;
      ws_q   <= ws_d;
      hs_q   <= hs_d;
      pl_q   <= pl_d;
      bc_q   <= bc_d;
      fe_q   <= fe_d;
      prod_q <= ws_q * hs_q;
    end
  end

endmodule

### sv/bphp_outq.sv
// ----------------------------------------------------------------------------
// bphp_outq
// Result queue: takes up to two results per cycle, hands out one per
// output transaction.
// ----------------------------------------------------------------------------
module bphp_outq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bphp_pkg::res_pair_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bphp_pkg::out_item_t  out_data_o
);

  localparam int unsigned PB = bphp_pkg::QPTR_BITS;
  localparam int unsigned CB = bphp_pkg::QCNT_BITS;

  bphp_pkg::out_item_t ent_q [bphp_pkg::QDEPTH];
  logic [PB-1:0] head_q, tail_q, tail_nx;
  logic [CB-1:0] cnt_q;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = ent_q[head_q];
  assign room_o      = (cnt_q <= CB'(bphp_pkg::QDEPTH - 2));
  assign tail_nx     = tail_q + PB'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) ent_q[tail_q] <= push_i.r0;
    if (push_i.num == 2'd2) ent_q[tail_nx] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_q + PB'(pop);
      tail_q <= tail_q + PB'(push_i.num);
      cnt_q  <= cnt_q + CB'(push_i.num) - CB'(pop);
    end
  end

endmodule

### sv/binary_pixmap_header_parser_top.sv
// ----------------------------------------------------------------------------
// binary_pixmap_header_parser_top
// Streaming P6 pixmap decoder: header parse, payload pass-through, status.
// ----------------------------------------------------------------------------
// Takes one encoded byte per cycle while in_ready_o is high. A byte lands in the
// input register and is parsed from there into a four-entry result queue once
// the queue has room; out_valid_o is driven from the registered queue count.
// A byte yields zero, one or two results (pixel or header, then a status on the
// final byte); a new byte is taken while the input register is empty or the
// queue has two free entries, so the sustained rate is one byte per cycle as
// long as results are drained at one per cycle.
// Write configuration only while the block holds no pending work.
module binary_pixmap_header_parser_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bphp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bphp_pkg::out_item_t  out_data_o
);

  bphp_pkg::cfg_t      cfg_q;
  logic                iv_q;
  bphp_pkg::in_item_t  item_q;
  logic                room, proc;
  bphp_pkg::res_pair_t res;

  assign proc       = iv_q && room;
  assign in_ready_o = !iv_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_dimension     <= bphp_pkg::DIM_BITS'(16383);
      cfg_q.max_channel_value <= 8'd255;
      cfg_q.max_encoded_bytes <= 32'hFFFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bphp_pkg::CFG_MAX_DIM:   cfg_q.max_dimension <= cfg_wdata_i[bphp_pkg::DIM_BITS-1:0];
        bphp_pkg::CFG_MAX_CHAN:  cfg_q.max_channel_value <= cfg_wdata_i[7:0];
        bphp_pkg::CFG_MAX_BYTES: cfg_q.max_encoded_bytes <= cfg_wdata_i;
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Input register: hold the transaction until the parser can take it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_data_i;
  end

  bphp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .item_vld_i (proc),
    .item_i     (item_q),
    .res_o      (res)
  );

  bphp_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sv/bphp_checker.sv
// ----------------------------------------------------------------------------
// bphp_checker
// Port-level checks of the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module bphp_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input bphp_pkg::out_item_t  out_data_o
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A status always closes the run of results for its byte
  a_status_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == bphp_pkg::KIND_STATUS |-> out_data_o.end_of_run)
    else $error("status without end_of_run");

  // Non-status results carry a zero status field
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != bphp_pkg::KIND_STATUS |->
      out_data_o.status == bphp_pkg::ST_OK)
    else $error("status set on non-status result");

  // An accepted header never reports a zero dimension
  a_hdr_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == bphp_pkg::KIND_HEADER |->
      out_data_o.image_width != '0 && out_data_o.image_height != '0)
    else $error("header with zero dimension");

endmodule

bind binary_pixmap_header_parser_top bphp_checker u_bphp_checker (.*);
